### src/sip_pkg.sv
// shared widths, constants and pipeline payload types for the segment intersection block
package sip_pkg;

  localparam int CW  = 32;               // coordinate width
  localparam int FB  = 16;               // fraction bits of a coordinate
  localparam int TW  = 16;               // tolerance register width
  localparam int TF  = 32;               // fraction bits of t and s
  localparam int DW  = CW + 1;           // coordinate difference width
  localparam int PW  = 2 * DW;           // product of two differences
  localparam int XW  = PW + 1;           // cross product width
  localparam int QB  = CW + 1;           // quotient bits of the collinear y division
  localparam int DS  = (QB > TF) ? QB : TF;
  localparam int NF  = 4;                // front stages
  localparam int NB  = 2;                // back stages, last one is the output register
  localparam int NST = NF + DS + NB;

  typedef logic signed [CW-1:0] coord_t;
  typedef logic signed [DW-1:0] diff_t;
  typedef logic signed [PW-1:0] prod_t;
  typedef logic signed [XW-1:0] wide_t;

  typedef struct packed {
    coord_t x1;
    coord_t y1;
    diff_t  dxa;
    diff_t  dya;
    coord_t mx;
    coord_t my;
    logic   closed;
    logic   vert;
    logic   span_x;
    logic   span_y;
    logic   near_d;
    logic   near_tn;
    logic   range_ok;
    logic   teq;
    logic   seq;
    logic   yneg;
  } sip_ctx_t;

  typedef struct packed {
    logic [XW-1:0] rt;
    logic [XW-1:0] rs;
    logic [XW-1:0] dv;
    logic [XW-1:0] ry;
    logic [DW-1:0] yden;
    logic [TF-1:0] tq;
    logic [TF-1:0] sq;
    logic [QB-1:0] yq;
  } sip_div_t;

endpackage

### src/sip_front.sv
// front stages: differences, middle values, cross products, sign normalization
module sip_front (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  sip_pkg::coord_t         a_start_x,
  input  sip_pkg::coord_t         a_start_y,
  input  sip_pkg::coord_t         a_end_x,
  input  sip_pkg::coord_t         a_end_y,
  input  sip_pkg::coord_t         b_start_x,
  input  sip_pkg::coord_t         b_start_y,
  input  sip_pkg::coord_t         b_end_x,
  input  sip_pkg::coord_t         b_end_y,
  input  logic                    closed_ends,
  input  logic [sip_pkg::TW-1:0]  tolerance,
  input  logic [sip_pkg::NF-1:0]  en,
  output logic [sip_pkg::NF-1:0]  v,
  output sip_pkg::sip_ctx_t       ctx,
  output sip_pkg::sip_div_t       dv
);

  localparam int CW = sip_pkg::CW;
  localparam int DW = sip_pkg::DW;
  localparam int XW = sip_pkg::XW;
  localparam int FB = sip_pkg::FB;
  localparam int TW = sip_pkg::TW;

  typedef struct packed {
    sip_pkg::coord_t x1, y1, x2, y2, x3, y3, x4, y4;
    sip_pkg::diff_t  dxa, dya, dxb, dyb, ex, ey, ny;
    sip_pkg::coord_t mx, my;
    logic            closed;
  } f1_t;

  typedef struct packed {
    sip_pkg::coord_t x1, y1;
    sip_pkg::diff_t  dxa, dya, ny, mdx;
    sip_pkg::coord_t mx, my;
    logic            closed, vert, span_x, span_y;
    sip_pkg::prod_t  pd1, pd2, pt1, pt2, ps1, ps2;
  } f2_t;

  typedef struct packed {
    sip_pkg::coord_t x1, y1;
    sip_pkg::diff_t  dxa, dya;
    sip_pkg::coord_t mx, my;
    logic            closed, vert, span_x, span_y;
    sip_pkg::wide_t  d, tn, sn;
    sip_pkg::prod_t  num;
  } f3_t;

  function automatic sip_pkg::diff_t dsub(sip_pkg::coord_t a, sip_pkg::coord_t b);
    return DW'(a) - DW'(b);
  endfunction

  function automatic logic [DW-1:0] dmag(sip_pkg::diff_t a);
    sip_pkg::diff_t n;
    n = -a;
    return a[DW-1] ? n : a;
  endfunction

  function automatic logic near(logic [DW-1:0] m, logic [TW-1:0] tol);
    return (m == '0) || (m < DW'(tol));
  endfunction

  function automatic sip_pkg::coord_t mid4(sip_pkg::coord_t a, sip_pkg::coord_t b,
                                           sip_pkg::coord_t c, sip_pkg::coord_t e);
    sip_pkg::coord_t v0, v1, v2, v3, h;
    logic signed [CW:0] sm;
    v0 = a; v1 = b; v2 = c; v3 = e;
    if (v0 > v1) begin h = v0; v0 = v1; v1 = h; end
    if (v2 > v3) begin h = v2; v2 = v3; v3 = h; end
    if (v0 > v2) begin h = v0; v0 = v2; v2 = h; end
    if (v1 > v3) begin h = v1; v1 = v3; v3 = h; end
    if (v1 > v2) begin h = v1; v1 = v2; v2 = h; end
    sm = (CW+1)'(v1) + (CW+1)'(v2);
    return sm[CW:1];
  endfunction

  function automatic logic span(sip_pkg::coord_t p1, sip_pkg::coord_t p2,
                                sip_pkg::coord_t p3, sip_pkg::coord_t p4,
                                logic cl, logic [TW-1:0] tol);
    sip_pkg::coord_t hia, loa, hib, lob;
    logic ov, n1, n2;
    hia = (p1 > p2) ? p1 : p2;
    loa = (p1 > p2) ? p2 : p1;
    hib = (p3 > p4) ? p3 : p4;
    lob = (p3 > p4) ? p4 : p3;
    ov  = !((hia < lob) || (loa > hib));
    n1  = near(dmag(dsub(hia, lob)), tol);
    n2  = near(dmag(dsub(loa, hib)), tol);
    return ov && (cl || !(n1 || n2));
  endfunction

  logic [sip_pkg::NF-1:0] v_r;
  f1_t               s1_r, s1_nxt;
  f2_t               s2_r, s2_nxt;
  f3_t               s3_r, s3_nxt;
  sip_pkg::sip_ctx_t ctx_r, ctx_nxt;
  sip_pkg::sip_div_t div_r, div_nxt;

  // stage 1: differences and middle of four
  always_comb begin
    s1_nxt.x1     = a_start_x;
    s1_nxt.y1     = a_start_y;
    s1_nxt.x2     = a_end_x;
    s1_nxt.y2     = a_end_y;
    s1_nxt.x3     = b_start_x;
    s1_nxt.y3     = b_start_y;
    s1_nxt.x4     = b_end_x;
    s1_nxt.y4     = b_end_y;
    s1_nxt.dxa    = dsub(a_end_x, a_start_x);
    s1_nxt.dya    = dsub(a_end_y, a_start_y);
    s1_nxt.dxb    = dsub(b_end_x, b_start_x);
    s1_nxt.dyb    = dsub(b_end_y, b_start_y);
    s1_nxt.ex     = dsub(a_start_x, b_start_x);
    s1_nxt.ey     = dsub(a_start_y, b_start_y);
    s1_nxt.ny     = dsub(a_start_y, a_end_y);
    s1_nxt.mx     = mid4(a_start_x, a_end_x, b_start_x, b_end_x);
    s1_nxt.my     = mid4(a_start_y, a_end_y, b_start_y, b_end_y);
    s1_nxt.closed = closed_ends;
  end

  // stage 2: products and overlap flags
  always_comb begin
    s2_nxt.x1     = s1_r.x1;
    s2_nxt.y1     = s1_r.y1;
    s2_nxt.dxa    = s1_r.dxa;
    s2_nxt.dya    = s1_r.dya;
    s2_nxt.ny     = s1_r.ny;
    s2_nxt.mdx    = dsub(s1_r.mx, s1_r.x1);
    s2_nxt.mx     = s1_r.mx;
    s2_nxt.my     = s1_r.my;
    s2_nxt.closed = s1_r.closed;
    s2_nxt.vert   = near(dmag(s1_r.dxa), tolerance);
    s2_nxt.span_x = span(s1_r.x1, s1_r.x2, s1_r.x3, s1_r.x4, s1_r.closed, tolerance);
    s2_nxt.span_y = span(s1_r.y1, s1_r.y2, s1_r.y3, s1_r.y4, s1_r.closed, tolerance);
    s2_nxt.pd1    = s1_r.dyb * s1_r.dxa;
    s2_nxt.pd2    = s1_r.dxb * s1_r.dya;
    s2_nxt.pt1    = s1_r.dxb * s1_r.ey;
    s2_nxt.pt2    = s1_r.dyb * s1_r.ex;
    s2_nxt.ps1    = s1_r.dxa * s1_r.ey;
    s2_nxt.ps2    = s1_r.dya * s1_r.ex;
  end

  // stage 3: cross products and collinear numerator
  always_comb begin
    s3_nxt.x1     = s2_r.x1;
    s3_nxt.y1     = s2_r.y1;
    s3_nxt.dxa    = s2_r.dxa;
    s3_nxt.dya    = s2_r.dya;
    s3_nxt.mx     = s2_r.mx;
    s3_nxt.my     = s2_r.my;
    s3_nxt.closed = s2_r.closed;
    s3_nxt.vert   = s2_r.vert;
    s3_nxt.span_x = s2_r.span_x;
    s3_nxt.span_y = s2_r.span_y;
    s3_nxt.d      = XW'(s2_r.pd1) - XW'(s2_r.pd2);
    s3_nxt.tn     = XW'(s2_r.pt1) - XW'(s2_r.pt2);
    s3_nxt.sn     = XW'(s2_r.ps1) - XW'(s2_r.ps2);
    s3_nxt.num    = s2_r.ny * s2_r.mdx;
  end

  // stage 4: sign normalization, near zero tests, divider operands
  logic           dneg, nneg;
  sip_pkg::wide_t dn, tnn, snn, tnm;
  sip_pkg::prod_t numn;
  logic [XW-1:0]  thr;
  logic [DW-1:0]  den;

  always_comb begin
    dneg = s3_r.d[XW-1];
    dn   = -s3_r.d;
    tnn  = dneg ? -s3_r.tn : s3_r.tn;
    snn  = dneg ? -s3_r.sn : s3_r.sn;
    if (dneg) begin
      dn = -s3_r.d;
    end else begin
      dn = s3_r.d;
    end
    tnm  = s3_r.tn[XW-1] ? -s3_r.tn : s3_r.tn;
    nneg = s3_r.num[sip_pkg::PW-1];
    numn = nneg ? -s3_r.num : s3_r.num;
    thr  = XW'({tolerance, {FB{1'b0}}});
    den  = dmag(s3_r.dxa);

    ctx_nxt.x1       = s3_r.x1;
    ctx_nxt.y1       = s3_r.y1;
    ctx_nxt.dxa      = s3_r.dxa;
    ctx_nxt.dya      = s3_r.dya;
    ctx_nxt.mx       = s3_r.mx;
    ctx_nxt.my       = s3_r.my;
    ctx_nxt.closed   = s3_r.closed;
    ctx_nxt.vert     = s3_r.vert;
    ctx_nxt.span_x   = s3_r.span_x;
    ctx_nxt.span_y   = s3_r.span_y;
    ctx_nxt.near_d   = (dn == '0) || (unsigned'(dn) < thr);
    ctx_nxt.near_tn  = (tnm == '0) || (unsigned'(tnm) < thr);
    ctx_nxt.range_ok = !tnn[XW-1] && !snn[XW-1] &&
                       (unsigned'(tnn) <= unsigned'(dn)) && (unsigned'(snn) <= unsigned'(dn));
    ctx_nxt.teq      = (tnn == dn);
    ctx_nxt.seq      = (snn == dn);
    ctx_nxt.yneg     = nneg ^ ~s3_r.dxa[DW-1];

    div_nxt.rt   = tnn;
    div_nxt.rs   = snn;
    div_nxt.dv   = dn;
    div_nxt.ry   = XW'(unsigned'(numn));
    div_nxt.yden = den;
    div_nxt.tq   = '0;
    div_nxt.sq   = '0;
    div_nxt.yq   = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= in_valid;
      if (en[1]) v_r[1] <= v_r[0];
      if (en[2]) v_r[2] <= v_r[1];
      if (en[3]) v_r[3] <= v_r[2];
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) s1_r <= s1_nxt;
    if (en[1]) s2_r <= s2_nxt;
    if (en[2]) s3_r <= s3_nxt;
    if (en[3]) begin
      ctx_r <= ctx_nxt;
      div_r <= div_nxt;
    end
  end

  assign v   = v_r;
  assign ctx = ctx_r;
  assign dv  = div_r;

endmodule

### src/sip_div.sv
// pipelined restoring dividers for t, s and the collinear y quotient, one bit per stage
module sip_div (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   v_in,
  input  sip_pkg::sip_div_t      d_in,
  input  sip_pkg::sip_ctx_t      c_in,
  input  logic [sip_pkg::DS-1:0] en,
  output logic [sip_pkg::DS-1:0] v,
  output sip_pkg::sip_div_t      d_out,
  output sip_pkg::sip_ctx_t      c_out
);

  localparam int XW = sip_pkg::XW;
  localparam int TF = sip_pkg::TF;
  localparam int QB = sip_pkg::QB;
  localparam int DS = sip_pkg::DS;

  logic [DS-1:0]     v_r;
  sip_pkg::sip_div_t d_r [DS];
  sip_pkg::sip_ctx_t c_r [DS];

  genvar j;
  for (j = 0; j < DS; j++) begin : g_stage
    localparam int SH = (j < QB) ? (QB - 1 - j) : 0;

    logic              vs;
    sip_pkg::sip_div_t ds;
    sip_pkg::sip_ctx_t cs;
    sip_pkg::sip_div_t d_nxt;
    logic [XW:0]       r2t, r2s, subt, subs;
    logic [XW-1:0]     dsh;
    logic              get, ges, gey;

    if (j == 0) begin : g_first
      assign vs = v_in;
      assign ds = d_in;
      assign cs = c_in;
    end else begin : g_next
      assign vs = v_r[j-1];
      assign ds = d_r[j-1];
      assign cs = c_r[j-1];
    end

    assign r2t  = {ds.rt, 1'b0};
    assign r2s  = {ds.rs, 1'b0};
    assign subt = r2t - {1'b0, ds.dv};
    assign subs = r2s - {1'b0, ds.dv};
    assign get  = r2t >= {1'b0, ds.dv};
    assign ges  = r2s >= {1'b0, ds.dv};
    assign dsh  = XW'(ds.yden) << SH;
    assign gey  = ds.ry >= dsh;

    always_comb begin
      d_nxt = ds;
      if (j < TF) begin
        d_nxt.rt = get ? subt[XW-1:0] : r2t[XW-1:0];
        d_nxt.rs = ges ? subs[XW-1:0] : r2s[XW-1:0];
        d_nxt.tq = {ds.tq[TF-2:0], get};
        d_nxt.sq = {ds.sq[TF-2:0], ges};
      end
      if (j < QB) begin
        d_nxt.ry     = gey ? (ds.ry - dsh) : ds.ry;
        d_nxt.yq[SH] = gey;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[j] <= 1'b0;
      end else if (en[j]) begin
        v_r[j] <= vs;
      end
    end

    always_ff @(posedge clk) begin
      if (en[j]) begin
        d_r[j] <= d_nxt;
        c_r[j] <= cs;
      end
    end
  end

  assign v     = v_r;
  assign d_out = d_r[DS-1];
  assign c_out = c_r[DS-1];

endmodule

### src/sip_back.sv
// back stages: end tests, point scaling, saturation and result select
module sip_back (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    v_in,
  input  sip_pkg::sip_div_t       d_in,
  input  sip_pkg::sip_ctx_t       c_in,
  input  logic [sip_pkg::TW-1:0]  tolerance,
  input  logic [sip_pkg::NB-1:0]  en,
  output logic [sip_pkg::NB-1:0]  v,
  output logic                    intersects,
  output sip_pkg::coord_t         cross_x,
  output sip_pkg::coord_t         cross_y
);

  localparam int CW  = sip_pkg::CW;
  localparam int DW  = sip_pkg::DW;
  localparam int FB  = sip_pkg::FB;
  localparam int TF  = sip_pkg::TF;
  localparam int QB  = sip_pkg::QB;
  localparam int TQW = TF + 1;
  localparam int MW  = TQW + 1 + DW;
  localparam int QSW = QB + 1;
  localparam int SW  = MW - TF + 1;
  localparam logic [TQW-1:0] ONE = {1'b1, {TF{1'b0}}};
  localparam logic signed [SW-1:0] SMAX = {{(SW-CW+1){1'b0}}, {(CW-1){1'b1}}};
  localparam logic signed [SW-1:0] SMIN = {{(SW-CW+1){1'b1}}, {(CW-1){1'b0}}};

  typedef struct packed {
    logic                   hit;
    logic                   near_d;
    logic                   vert;
    sip_pkg::coord_t        x1, y1, mx, my;
    logic signed [MW-1:0]   pxm, pym;
    logic signed [QSW-1:0]  qs;
  } b1_t;

  function automatic logic at_end(logic [TQW-1:0] q, logic [TQW-1:0] k);
    logic [TQW-1:0] rest;
    rest = ONE - q;
    return (q == '0) || (q < k) || (q == ONE) || (rest < k);
  endfunction

  function automatic sip_pkg::coord_t sat(logic signed [SW-1:0] a);
    if (a > SMAX) return SMAX[CW-1:0];
    if (a < SMIN) return SMIN[CW-1:0];
    return a[CW-1:0];
  endfunction

  logic [sip_pkg::NB-1:0] v_r;
  b1_t                    b1_r, b1_nxt;
  logic                   hit_r;
  sip_pkg::coord_t        cx_r, cy_r, cx_nxt, cy_nxt;

  logic [TQW-1:0]         tqf, sqf, k;
  logic                   end_ok;
  logic signed [QSW-1:0]  qpos;

  always_comb begin
    tqf    = c_in.teq ? ONE : {1'b0, d_in.tq};
    sqf    = c_in.seq ? ONE : {1'b0, d_in.sq};
    k      = TQW'({tolerance, {(TF-FB){1'b0}}});
    end_ok = c_in.closed || !(at_end(tqf, k) || at_end(sqf, k));
    qpos   = $signed({1'b0, d_in.yq});

    b1_nxt.near_d = c_in.near_d;
    b1_nxt.vert   = c_in.vert;
    b1_nxt.x1     = c_in.x1;
    b1_nxt.y1     = c_in.y1;
    b1_nxt.mx     = c_in.mx;
    b1_nxt.my     = c_in.my;
    b1_nxt.pxm    = $signed({1'b0, tqf}) * c_in.dxa;
    b1_nxt.pym    = $signed({1'b0, tqf}) * c_in.dya;
    b1_nxt.qs     = c_in.yneg ? -qpos : qpos;
    if (c_in.near_d) begin
      if (c_in.near_tn) begin
        b1_nxt.hit = c_in.vert ? c_in.span_y : c_in.span_x;
      end else begin
        b1_nxt.hit = 1'b0;
      end
    end else begin
      b1_nxt.hit = c_in.range_ok && end_ok;
    end
  end

  logic signed [MW-1:0] shx, shy;
  logic signed [SW-1:0] sumx, sumy, sumc;

  always_comb begin
    shx  = b1_r.pxm >>> TF;
    shy  = b1_r.pym >>> TF;
    sumx = SW'(shx) + SW'(b1_r.x1);
    sumy = SW'(shy) + SW'(b1_r.y1);
    sumc = SW'(b1_r.qs) + SW'(b1_r.y1);
    if (!b1_r.hit) begin
      cx_nxt = '0;
      cy_nxt = '0;
    end else if (b1_r.near_d) begin
      cx_nxt = b1_r.vert ? b1_r.x1 : b1_r.mx;
      cy_nxt = b1_r.vert ? b1_r.my : sat(sumc);
    end else begin
      cx_nxt = sat(sumx);
      cy_nxt = sat(sumy);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= v_in;
      if (en[1]) v_r[1] <= v_r[0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) b1_r <= b1_nxt;
    if (en[1]) begin
      hit_r <= b1_r.hit;
      cx_r  <= cx_nxt;
      cy_r  <= cy_nxt;
    end
  end

  assign v          = v_r;
  assign intersects = hit_r;
  assign cross_x    = cx_r;
  assign cross_y    = cy_r;

endmodule

### src/segment_intersection_point.sv
// top level: tolerance register, stage enables and the front, divider and back pipelines
// stages from an input transfer to its result: 4 front, 33 divider, 2 back
// throughput: one segment pair per cycle unless a full pipeline is stalled at the output
// a stalled output holds only the unbroken run of full stages behind it; other stages keep moving
// reset: synchronous active-low rst_n empties every stage and sets tolerance to 1
module segment_intersection_point (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  sip_pkg::coord_t        in_a_start_x,
  input  sip_pkg::coord_t        in_a_start_y,
  input  sip_pkg::coord_t        in_a_end_x,
  input  sip_pkg::coord_t        in_a_end_y,
  input  sip_pkg::coord_t        in_b_start_x,
  input  sip_pkg::coord_t        in_b_start_y,
  input  sip_pkg::coord_t        in_b_end_x,
  input  sip_pkg::coord_t        in_b_end_y,
  input  logic                   in_closed_ends,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   out_intersects,
  output sip_pkg::coord_t        out_cross_x,
  output sip_pkg::coord_t        out_cross_y,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [sip_pkg::TW-1:0] cfg_data
);

  localparam int NF  = sip_pkg::NF;
  localparam int DS  = sip_pkg::DS;
  localparam int NB  = sip_pkg::NB;
  localparam int NST = sip_pkg::NST;

  logic [sip_pkg::TW-1:0] tolerance_r;
  logic [NST-1:0]         vall, en;
  logic [NF-1:0]          vf;
  logic [DS-1:0]          vd;
  logic [NB-1:0]          vb;
  sip_pkg::sip_ctx_t      ctx_f, ctx_d;
  sip_pkg::sip_div_t      div_f, div_d;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tolerance_r <= sip_pkg::TW'(1);
    end else if (cfg_valid && cfg_ready) begin
      tolerance_r <= cfg_data;
    end
  end

  assign vall = {vb, vd, vf};

  // a stage moves when the output drains or some stage at or after it is empty
  genvar k;
  for (k = 0; k < NST; k++) begin : g_en
    assign en[k] = out_ready | ~(&vall[NST-1:k]);
  end

  assign in_ready  = en[0];
  assign out_valid = vb[NB-1];

  sip_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .a_start_x   (in_a_start_x),
    .a_start_y   (in_a_start_y),
    .a_end_x     (in_a_end_x),
    .a_end_y     (in_a_end_y),
    .b_start_x   (in_b_start_x),
    .b_start_y   (in_b_start_y),
    .b_end_x     (in_b_end_x),
    .b_end_y     (in_b_end_y),
    .closed_ends (in_closed_ends),
    .tolerance   (tolerance_r),
    .en          (en[NF-1:0]),
    .v           (vf),
    .ctx         (ctx_f),
    .dv          (div_f)
  );

  sip_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .v_in  (vf[NF-1]),
    .d_in  (div_f),
    .c_in  (ctx_f),
    .en    (en[NF+DS-1:NF]),
    .v     (vd),
    .d_out (div_d),
    .c_out (ctx_d)
  );

  sip_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .v_in       (vd[DS-1]),
    .d_in       (div_d),
    .c_in       (ctx_d),
    .tolerance  (tolerance_r),
    .en         (en[NST-1:NF+DS]),
    .v          (vb),
    .intersects (out_intersects),
    .cross_x    (out_cross_x),
    .cross_y    (out_cross_y)
  );

  a_reset_empty : assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_miss_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_intersects |-> out_cross_x == '0 && out_cross_y == '0)
    else $error("nonzero point on a miss");

  a_stall_cause : assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready && (&vall))
    else $error("input blocked without a full stalled pipeline");

endmodule
